[hdl/wms_pkg.sv]
package wms_pkg;

	// special characters of the reply search
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_K      = 8'h4B;
	localparam logic [7:0] CH_PROMPT = 8'h3E;

	// link tails
	localparam logic [31:0] LINK_UP_TAIL   = 32'h2002_0000;
	localparam logic [23:0] LINK_DOWN_TAIL = 24'h64_0160;

	// register reset values
	localparam logic       REPLY_MODE_RST = 1'b1;
	localparam logic [7:0] WRAP_LIMIT_RST = 8'd150;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_REPLY_MODE = 1'b0,
		REG_WRAP_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       reply_mode;
		logic [7:0] wrap_limit;
	} cfg_t;

	// one result beat; fields listed from the msb of m_tdata down
	typedef struct packed {
		logic       history_wrapped;
		logic       link_up;
		logic [7:0] message_index;
		logic [7:0] message_byte;
		logic       message_valid;
		logic [7:0] msg_len;
		logic       message_start;
		logic       reply_seen;
	} result_t;

endpackage

[hdl/wifi_module_reply_scanner.sv]
// A byte accepted into the input register passes to the result register, which drives m_tvalid.
// Throughput: one byte per cycle; the input register advances whenever the result
//   register is empty or its beat is taken in the same cycle.
// Reset (arst_n low, asynchronous): scanner state cleared, link down, reply_mode 1,
//   wrap_limit 150, both stream registers empty.
module wifi_module_reply_scanner (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// receive stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [0] reply_seen, [1] message_start,
	                               // [9:2] msg_len, [10] message_valid,
	                               // [18:11] message_byte, [26:19] message_index,
	                               // [27] link_up, [28] history_wrapped, [31:29] zero
);

	wms_pkg::cfg_t    cfg;
	wms_pkg::result_t res, res_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance;

	wms_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held byte moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	// scanner state updates once per byte, as the result is captured
	wms_scan_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, res_q};

`ifndef SYNTHESIS
	// a started message never has zero length
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.message_start |-> res_q.msg_len != 8'd0)
		else $error("message_start with zero length");

	// a body byte on a wrapping beat is lost and reads as zero
	a_wrap_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.message_valid && res_q.history_wrapped
		|-> res_q.message_byte == 8'd0)
		else $error("body byte survived a wrap");

	// no message output without the control-mode reply flag
	a_reply_msg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.reply_seen
		|-> !res_q.message_valid && !res_q.message_start)
		else $error("message output in reply mode");

	// a stalled byte stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("held byte lost");
`endif

endmodule

[hdl/wms_apb_regs.sv]
module wms_apb_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output wms_pkg::cfg_t    cfg
);

	logic             wr_en;
	wms_pkg::reg_idx_t idx;
	wms_pkg::cfg_t    cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = wms_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reply_mode <= wms_pkg::REPLY_MODE_RST;
			cfg_q.wrap_limit <= wms_pkg::WRAP_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				wms_pkg::REG_REPLY_MODE: cfg_q.reply_mode <= pwdata[0];
				wms_pkg::REG_WRAP_LIMIT: cfg_q.wrap_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			wms_pkg::REG_REPLY_MODE: prdata = {31'd0, cfg_q.reply_mode};
			wms_pkg::REG_WRAP_LIMIT: prdata = {24'd0, cfg_q.wrap_limit};
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[hdl/wms_scan_core.sv]
module wms_scan_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  wms_pkg::cfg_t      cfg,
	output wms_pkg::result_t   res
);

	logic [31:0] recent_q, recent_n, shifted;
	logic [7:0]  pos_q, pos_n, left_q, left_n, bidx_q, bidx_n;
	logic        opend_q, opend_n, nblk_q, nblk_n, conn_q, conn_n;

	logic        hit;
	logic [8:0]  pos_inc;
	logic [7:0]  cur, pos_use;

	always_comb begin
		shifted  = {recent_q[23:0], rx_byte};
		recent_n = shifted;
		pos_n    = pos_q;
		left_n   = left_q;
		bidx_n   = bidx_q;
		opend_n  = opend_q;
		nblk_n   = nblk_q;
		conn_n   = conn_q;
		hit      = 1'b0;
		pos_inc  = {1'b0, pos_q} + 9'd1;
		cur      = rx_byte;
		pos_use  = pos_q;
		res      = '0;

		// link tail sees the new byte before any clear
		if (shifted == wms_pkg::LINK_UP_TAIL)
			conn_n = 1'b1;
		if (shifted[23:0] == wms_pkg::LINK_DOWN_TAIL)
			conn_n = 1'b0;

		// string-search view
		if (!nblk_q) begin
			if (rx_byte == 8'd0) begin
				nblk_n  = 1'b1;
				opend_n = 1'b0;
			end else begin
				hit     = (rx_byte == wms_pkg::CH_PROMPT) ||
				          (rx_byte == wms_pkg::CH_K && opend_q);
				opend_n = (rx_byte == wms_pkg::CH_O);
			end
		end

		if (cfg.reply_mode) begin
			if (hit) begin
				res.reply_seen = 1'b1;
				recent_n = '0;
				pos_n    = '0;
				opend_n  = 1'b0;
				nblk_n   = 1'b0;
			end else if (pos_inc >= {1'b0, cfg.wrap_limit}) begin
				res.history_wrapped = 1'b1;
				recent_n = '0;
				pos_n    = '0;
				opend_n  = 1'b0;
				nblk_n   = 1'b0;
			end else begin
				pos_n = pos_inc[7:0];
			end
		end else begin
			res.reply_seen = 1'b1;
			// wrap drops this byte; history holds one zero
			if (pos_q >= cfg.wrap_limit) begin
				res.history_wrapped = 1'b1;
				recent_n = '0;
				opend_n  = 1'b0;
				nblk_n   = 1'b1;
				cur      = 8'd0;
				pos_use  = 8'd0;
			end
			if (left_q != 8'd0) begin
				res.message_valid = 1'b1;
				res.message_byte  = cur;
				res.message_index = bidx_q;
				if (bidx_q != 8'hFF)
					bidx_n = bidx_q + 8'd1;
				left_n = left_q - 8'd1;
			end
			if (pos_use > 8'd3 && recent_n[23:8] == 16'd0 && cur != 8'd0) begin
				res.message_start = 1'b1;
				res.msg_len       = cur;
				left_n = cur;
				bidx_n = 8'd0;
			end
			pos_n = (pos_use == 8'hFF) ? 8'hFF : pos_use + 8'd1;
		end

		res.link_up = conn_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			pos_q    <= '0;
			left_q   <= '0;
			bidx_q   <= '0;
			opend_q  <= 1'b0;
			nblk_q   <= 1'b0;
			conn_q   <= 1'b0;
		end else if (step) begin
			recent_q <= recent_n;
			pos_q    <= pos_n;
			left_q   <= left_n;
			bidx_q   <= bidx_n;
			opend_q  <= opend_n;
			nblk_q   <= nblk_n;
			conn_q   <= conn_n;
		end
	end

endmodule

[sim/reply_scan_checker.sv]
module reply_scan_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // result_t from bit 0 up, [31:29] zero
	input  logic        end_of_run,
	output int          fail_count,
	output int          outstanding,
	output int          beats_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies, tracked from the config bus
	logic       mode;
	logic [7:0] limit;

	// scanner state
	logic [31:0] hist;
	logic [7:0]  pos;
	logic [7:0]  left;
	logic [7:0]  body_idx;
	logic        o_pend;
	logic        null_blk;
	logic        link;

	wms_pkg::result_t expected_beats[$];

	function automatic void wipe_history();
		hist = '0;
		pos = '0;
		o_pend = 1'b0;
		null_blk = 1'b0;
	endfunction

	function automatic wms_pkg::result_t scan_byte(input logic [7:0] b);
		wms_pkg::result_t r;
		logic       hit;
		logic [8:0] npos;
		logic [7:0] cur;
		r = '0;
		hit = 1'b0;
		hist = {hist[23:0], b};
		if (hist == wms_pkg::LINK_UP_TAIL)
			link = 1'b1;
		if (hist[23:0] == wms_pkg::LINK_DOWN_TAIL)
			link = 1'b0;
		// string-search view: a zero byte ends the searchable history
		if (!null_blk) begin
			if (b == 8'h00) begin
				null_blk = 1'b1;
				o_pend = 1'b0;
			end else begin
				hit = (b == wms_pkg::CH_PROMPT) || (b == wms_pkg::CH_K && o_pend);
				o_pend = (b == wms_pkg::CH_O);
			end
		end
		if (mode) begin
			if (hit) begin
				r.reply_seen = 1'b1;
				wipe_history();
			end else begin
				npos = {1'b0, pos} + 9'd1;
				if (npos >= {1'b0, limit}) begin
					wipe_history();
					r.history_wrapped = 1'b1;
				end else begin
					pos = npos[7:0];
				end
			end
		end else begin
			cur = b;
			r.reply_seen = 1'b1;
			// wrap drops this byte: history becomes one zero byte
			if (pos >= limit) begin
				wipe_history();
				null_blk = 1'b1;
				r.history_wrapped = 1'b1;
				cur = 8'h00;
			end
			if (left != 8'h00) begin
				r.message_valid = 1'b1;
				r.message_byte = cur;
				r.message_index = body_idx;
				if (body_idx != 8'hFF)
					body_idx = body_idx + 8'd1;
				left = left - 8'd1;
			end
			if (pos > 8'd3 && hist[23:8] == 16'h0000 && cur != 8'h00) begin
				r.message_start = 1'b1;
				r.msg_len = cur;
				left = cur;
				body_idx = '0;
			end
			if (pos != 8'hFF)
				pos = pos + 8'd1;
		end
		r.link_up = link;
		return r;
	endfunction

	function automatic string beat_text(input wms_pkg::result_t r);
		return $sformatf({"reply=%0b start=%0b len=%0d valid=%0b byte=%0d idx=%0d",
			" link=%0b wrap=%0b"},
			r.reply_seen, r.message_start, r.msg_len, r.message_valid,
			r.message_byte, r.message_index, r.link_up, r.history_wrapped);
	endfunction

	function automatic void note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wms_pkg::result_t want;
		wms_pkg::result_t got;
		if (!arst_n) begin
			mode = wms_pkg::REPLY_MODE_RST;
			limit = wms_pkg::WRAP_LIMIT_RST;
			wipe_history();
			left = '0;
			body_idx = '0;
			link = 1'b0;
			expected_beats.delete();
			fail_count = 0;
			outstanding = 0;
			beats_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(wms_pkg::result_t)-1:0];
				beats_seen++;
				if (expected_beats.size() == 0) begin
					note_failure($sformatf("beat with no byte waiting: %s",
						beat_text(got)));
				end else begin
					want = expected_beats.pop_front();
					if (got !== want || m_tdata[31:$bits(wms_pkg::result_t)] !== '0)
						note_failure($sformatf("beat %0d expected %s got %s pad=%0h",
							beats_seen, beat_text(want), beat_text(got),
							m_tdata[31:$bits(wms_pkg::result_t)]));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (wms_pkg::reg_idx_t'(paddr[2]))
					wms_pkg::REG_REPLY_MODE: mode = pwdata[0];
					wms_pkg::REG_WRAP_LIMIT: limit = pwdata[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_beats.push_back(scan_byte(s_tdata));
			if (end_of_run && expected_beats.size() != 0) begin
				note_failure($sformatf("%0d expected beats never arrived",
					expected_beats.size()));
				expected_beats.delete();
			end
			outstanding = expected_beats.size();
		end
	end

endmodule

[sim/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// receiver hold-off long enough to back the block up into its input
	localparam int HOLD_CYCLES = 40;

	typedef enum int {
		PH_PLAIN,
		PH_HOLD,
		PH_PAUSE,
		PH_LONG_MSG
	} twist_t;

	typedef enum int {
		CK_FRAME,
		CK_LINK_UP,
		CK_LINK_DOWN,
		CK_NOISE,
		CK_OK,
		CK_PROMPT,
		CK_BROKEN_OK,
		CK_TEXT,
		CK_NUL
	} chunk_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [0] reply_seen, [1] message_start, [9:2] msg_len,
	                        // [10] message_valid, [18:11] message_byte,
	                        // [26:19] message_index, [27] link_up, [28] history_wrapped

	logic        end_of_run;
	int          fail_count;
	int          outstanding;
	int          beats_seen;

	// stimulus bookkeeping
	logic [7:0]  pending[$];     // bytes queued for the receive stream
	bit          idling;         // random gaps on both sides when set
	int          hold_asks;      // bumped by stimulus to ask for a long hold-off
	int          bytes_sent;
	int          settings_used;

	wifi_module_reply_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	reply_scan_checker scan_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.end_of_run  (end_of_run),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.beats_seen  (beats_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: ready in random low bursts, or a long counted hold-off on request.
	// One assignment per falling edge at most.
	initial begin
		int held;
		int burst;
		int holds_done;
		m_tready = 1'b0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				m_tready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
			end else if (idling && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9);
				m_tready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#400_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Config write: setup cycle, then access cycle; lands on the edge with penable high.
	// The bus is left idle before the task returns.
	task automatic write_reg(input wms_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// One receive beat. Called at a falling edge, returns at the falling edge after
	// the beat was taken. tvalid stays high into the next call unless a gap is drawn.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (idling && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic drain();
		while (pending.size() != 0)
			send_byte(pending.pop_front());
	endtask

	// drop tvalid and wait for every expected beat to come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Queue one chunk of traffic. Control phases mostly get framed messages
	// (two zeros, length, body, sometimes cut short); reply phases mostly get OK / prompt
	// tokens, text, link tails and noise, with a rare zero that blocks the search.
	task automatic queue_chunk(input logic reply_phase);
		chunk_kind_t kind;
		int len;
		int cut;
		if (reply_phase)
			kind = ($urandom_range(0, 15) == 0) ? CK_FRAME :
				chunk_kind_t'($urandom_range(CK_LINK_UP, CK_NUL));
		else
			kind = ($urandom_range(0, 2) == 0) ?
				chunk_kind_t'($urandom_range(CK_LINK_UP, CK_NUL)) : CK_FRAME;
		case (kind)
			CK_FRAME: begin
				repeat ($urandom_range(0, 3))
					pending.push_back(8'($urandom_range(8'h21, 8'h7E)));
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 60) :
					$urandom_range(1, 12);
				pending.push_back(8'h00);
				pending.push_back(8'h00);
				pending.push_back(8'(len));
				cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
				repeat (cut) pending.push_back(8'($urandom));
			end
			CK_LINK_UP: begin
				pending.push_back(wms_pkg::LINK_UP_TAIL[31:24]);
				pending.push_back(wms_pkg::LINK_UP_TAIL[23:16]);
				pending.push_back(wms_pkg::LINK_UP_TAIL[15:8]);
				pending.push_back(wms_pkg::LINK_UP_TAIL[7:0]);
			end
			CK_LINK_DOWN: begin
				pending.push_back(wms_pkg::LINK_DOWN_TAIL[23:16]);
				pending.push_back(wms_pkg::LINK_DOWN_TAIL[15:8]);
				pending.push_back(wms_pkg::LINK_DOWN_TAIL[7:0]);
			end
			CK_NOISE: repeat ($urandom_range(1, 6)) pending.push_back(8'($urandom));
			CK_OK: begin
				pending.push_back(wms_pkg::CH_O);
				pending.push_back(wms_pkg::CH_K);
			end
			CK_PROMPT: pending.push_back(wms_pkg::CH_PROMPT);
			CK_BROKEN_OK: begin
				pending.push_back(wms_pkg::CH_O);
				pending.push_back(8'($urandom_range(8'h01, 8'hFF)));
				pending.push_back(wms_pkg::CH_K);
			end
			CK_TEXT: repeat ($urandom_range(1, 5))
				pending.push_back(8'($urandom_range(8'h20, 8'h7E)));
			default: pending.push_back(8'h00);
		endcase
	endtask

	// One register setting, written while idle, then random traffic.
	task automatic run_phase(input logic mode, input logic [7:0] limit, input int budget,
		input twist_t twist);
		int first;
		bit paused;
		settle();
		write_reg(wms_pkg::REG_REPLY_MODE, {31'b0, mode});
		write_reg(wms_pkg::REG_WRAP_LIMIT, {24'b0, limit});
		settings_used++;
		first = bytes_sent;
		paused = 1'b0;
		// the receiver stalls while bytes keep coming
		if (twist == PH_HOLD)
			hold_asks++;
		// longest message: its body runs across a history wrap
		if (twist == PH_LONG_MSG) begin
			repeat (3) pending.push_back(8'($urandom_range(8'h21, 8'h7E)));
			pending.push_back(8'h00);
			pending.push_back(8'h00);
			pending.push_back(8'hFF);
			repeat (255) pending.push_back(8'($urandom));
			drain();
		end
		while (bytes_sent - first < budget) begin
			queue_chunk(mode);
			drain();
			// sender goes quiet mid-phase until every beat is back
			if (twist == PH_PAUSE && !paused && bytes_sent - first >= budget / 2) begin
				paused = 1'b1;
				settle();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		end_of_run = 1'b0;
		idling = 1'b1;
		hold_asks = 0;
		bytes_sent = 0;
		settings_used = 1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reply mode at reset values: OK match, prompt match, O broken before K,
		// byte extremes, link-up tail (its zeros block the search, so the next OK
		// is not seen), then the link-down tail.
		pending = '{wms_pkg::CH_O, wms_pkg::CH_K, wms_pkg::CH_PROMPT, wms_pkg::CH_O,
			8'h58, wms_pkg::CH_K, 8'hFF,
			wms_pkg::LINK_UP_TAIL[31:24], wms_pkg::LINK_UP_TAIL[23:16],
			wms_pkg::LINK_UP_TAIL[15:8], wms_pkg::LINK_UP_TAIL[7:0],
			wms_pkg::CH_O, wms_pkg::CH_K,
			wms_pkg::LINK_DOWN_TAIL[23:16], wms_pkg::LINK_DOWN_TAIL[15:8],
			wms_pkg::LINK_DOWN_TAIL[7:0]};
		drain();

		// Control mode: two text bytes, zero zero, length 3, three body bytes.
		settle();
		write_reg(wms_pkg::REG_REPLY_MODE, 32'd0);
		write_reg(wms_pkg::REG_WRAP_LIMIT, 32'd20);
		settings_used++;
		pending = '{8'h41, 8'h42, 8'h00, 8'h00, 8'h03, 8'h11, 8'hFF, 8'h7E};
		drain();

		run_phase(1'b0, 8'd20, 140, PH_PLAIN);
		run_phase(1'b1, 8'd4, 120, PH_PAUSE);
		run_phase(1'b0, 8'd255, 40, PH_LONG_MSG);
		// back to reply mode with control history still in place
		run_phase(1'b1, 8'd150, 140, PH_PLAIN);
		run_phase(1'b0, 8'd4, 120, PH_HOLD);
		// limits below the legal floor: wrap on every byte but a reply match
		run_phase(1'b0, 8'd0, 40, PH_PLAIN);
		run_phase(1'b1, 8'd1, 40, PH_PLAIN);
		run_phase(1'b1, 8'($urandom_range(4, 255)), 140, PH_PLAIN);
		run_phase(1'b0, 8'($urandom_range(4, 255)), 140, PH_HOLD);
		// closing stretch at full rate on both sides
		idling = 1'b0;
		run_phase(1'b1, 8'd255, 130, PH_PLAIN);
		run_phase(1'b0, 8'd60, 130, PH_PLAIN);

		settle();
		repeat (3) @(negedge clk);
		end_of_run <= 1'b1;
		repeat (2) @(negedge clk);

		$display("Fed %0d bytes across %0d register settings; %0d result beats compared.",
			bytes_sent, settings_used, beats_seen);
		$display("Traffic: framed messages, reply tokens, link tails, noise, limits 0 to 255.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
hdl/wms_pkg.sv
hdl/wms_apb_regs.sv
hdl/wms_scan_core.sv
hdl/wifi_module_reply_scanner.sv
sim/reply_scan_checker.sv
sim/testbench.sv
